@@ rtl/rts_pkg.sv @@
package rts_pkg;

    localparam int MAX_ENTRIES = 16;

    typedef enum logic [2:0] {
        CMD_TICK     = 3'd0,
        CMD_SCHEDULE = 3'd1,
        CMD_SLEEP    = 3'd2,
        CMD_ADD_THR  = 3'd3,
        CMD_ADD_PER  = 3'd4,
        CMD_SET_BLK  = 3'd5
    } cmd_t;

    localparam logic [2:0] KIND_FIRE = 3'd0;
    localparam logic [2:0] KIND_OK   = 3'd1;
    localparam logic [2:0] KIND_DONE = 3'd2;
    localparam logic [2:0] KIND_FULL = 3'd3;
    localparam logic [2:0] KIND_NONE = 3'd4;

    typedef struct packed {
        logic load;
        logic time_inc;
        logic per_upd;
        logic thr_wake;
        logic sched_take;
        logic sleep_wr;
        logic add_thr;
        logic add_per;
        logic set_blk;
        logic scan_clr;
        logic scan_inc;
    } rts_cmd_t;

    typedef struct packed {
        logic per_hit;
        logic runnable;
        logic per_end;
        logic thr_end;
        logic sched_end;
        logic sched_empty;
        logic thr_full;
        logic per_full;
        logic blk_ok;
        logic sleep_ok;
    } rts_status_t;

endpackage

@@ rtl/rtos_tick_scheduler.sv @@
// Channel  | Handshake             | Payload
// input    | in_valid / in_stall   | command, thread_index, amount, blocked_flag
// output   | out_valid / out_stall | kind, index, now, last
//
// No new request is taken until the last is done. A tick advances the time, then
// scans the periodic and then the thread table, each entry in a read and a check state.
// A schedule tries the threads in turn from the one after the current thread, and
// reports none when no thread is runnable or the table is empty.
// Reset clears the time, the counts, the current thread and all marks.
// A stalled output holds the controller until the result register frees.
module rtos_tick_scheduler
    import rts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  command,
    input  logic [3:0]  thread_index,
    input  logic [31:0] amount,
    input  logic        blocked_flag,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [3:0]  index,
    output logic [31:0] now,
    output logic        last
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);

    rts_cmd_t    cmd;
    rts_status_t status;
    logic [CW-1:0] scan_idx, thr_cnt, per_cnt, cand_idx, cur_thr;
    logic [31:0] sys_time;

    rts_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .command(command),
        .out_valid(out_valid), .out_stall(out_stall),
        .kind(kind), .index(index), .now(now), .last(last),
        .cmd(cmd), .status(status),
        .scan_idx(scan_idx), .thr_cnt(thr_cnt), .per_cnt(per_cnt),
        .cand_idx(cand_idx), .cur_thr(cur_thr), .sys_time(sys_time)
    );

    rts_datapath u_dp (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .status(status),
        .thread_index(thread_index), .amount(amount), .blocked_flag(blocked_flag),
        .scan_idx(scan_idx), .thr_cnt(thr_cnt), .per_cnt(per_cnt),
        .cand_idx(cand_idx), .cur_thr(cur_thr), .now(sys_time)
    );

endmodule

@@ rtl/rts_datapath.sv @@
module rts_datapath
    import rts_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  rts_cmd_t                          cmd,
    output rts_status_t                       status,
    input  logic [3:0]                        thread_index,
    input  logic [31:0]                       amount,
    input  logic                              blocked_flag,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]  scan_idx,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]  thr_cnt,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]  per_cnt,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]  cand_idx,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]  cur_thr,
    output logic [31:0]                       now
);

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

    logic [31:0] sys_time_reg;
    logic [CW-1:0] cur_reg, tcnt_reg, pcnt_reg, scan_reg, cand_reg;
    logic [MAX_ENTRIES-1:0] asleep_reg, blocked_reg;
    logic [31:0] wake_mem [MAX_ENTRIES];
    logic [31:0] rel_mem [MAX_ENTRIES];
    logic [31:0] per_mem [MAX_ENTRIES];
    logic [31:0] rel_rd_reg, per_rd_reg, wake_rd_reg;
    logic [3:0] tix_reg;
    logic [31:0] amt_reg;
    logic flag_reg;
    logic [CW-1:0] cand_next;
    logic [AW-1:0] scan_a, cand_a, tix_a, cur_a, tcnt_a, pcnt_a;

    assign scan_a = scan_reg[AW-1:0];
    assign cand_a = cand_reg[AW-1:0];
    assign cur_a  = cur_reg[AW-1:0];
    assign tcnt_a = tcnt_reg[AW-1:0];
    assign pcnt_a = pcnt_reg[AW-1:0];
    assign tix_a  = tix_reg[AW-1:0];

    always_comb
    begin
        if (cur_reg + CW'(1) >= tcnt_reg)
            cand_next = '0;
        else
            cand_next = cur_reg + CW'(1);
        if (cmd.scan_inc)
            cand_next = (cand_reg + CW'(1) >= tcnt_reg) ? '0 : cand_reg + CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sys_time_reg <= '0;
            cur_reg      <= '0;
            tcnt_reg     <= '0;
            pcnt_reg     <= '0;
            scan_reg     <= '0;
            cand_reg     <= '0;
            asleep_reg   <= '0;
            blocked_reg  <= '0;
        end
        else
        begin
            if (cmd.time_inc)
                sys_time_reg <= sys_time_reg + 32'd1;
            if (cmd.scan_clr)
            begin
                scan_reg <= '0;
                cand_reg <= cand_next;
            end
            else if (cmd.scan_inc)
            begin
                scan_reg <= scan_reg + CW'(1);
                cand_reg <= cand_next;
            end
            if (cmd.sched_take)
                cur_reg <= cand_reg;
            if (cmd.thr_wake && asleep_reg[scan_a] && wake_rd_reg == sys_time_reg)
                asleep_reg[scan_a] <= 1'b0;
            if (cmd.sleep_wr)
                asleep_reg[cur_a] <= 1'b1;
            if (cmd.add_thr)
            begin
                asleep_reg[tcnt_a]  <= 1'b0;
                blocked_reg[tcnt_a] <= 1'b0;
                tcnt_reg <= tcnt_reg + CW'(1);
            end
            if (cmd.add_per)
                pcnt_reg <= pcnt_reg + CW'(1);
            if (cmd.set_blk)
                blocked_reg[tix_a] <= flag_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            tix_reg  <= thread_index;
            amt_reg  <= amount;
            flag_reg <= blocked_flag;
        end
        rel_rd_reg  <= rel_mem[scan_a];
        per_rd_reg  <= per_mem[scan_a];
        wake_rd_reg <= wake_mem[scan_a];
        if (cmd.per_upd)
            rel_mem[scan_a] <= sys_time_reg + per_rd_reg;
        if (cmd.add_per)
        begin
            rel_mem[pcnt_a] <= sys_time_reg + amt_reg;
            per_mem[pcnt_a] <= amt_reg;
        end
        if (cmd.sleep_wr)
            wake_mem[cur_a] <= sys_time_reg + amt_reg;
    end

    assign status.per_hit     = (rel_rd_reg == sys_time_reg);
    assign status.runnable    = !blocked_reg[cand_a] && !asleep_reg[cand_a];
    assign status.per_end     = (scan_reg >= pcnt_reg);
    assign status.thr_end     = (scan_reg >= tcnt_reg);
    assign status.sched_end   = (scan_reg + CW'(1) >= tcnt_reg);
    assign status.sched_empty = (tcnt_reg == '0) || (cur_reg >= tcnt_reg);
    assign status.thr_full    = (tcnt_reg >= CW'(MAX_ENTRIES));
    assign status.per_full    = (pcnt_reg >= CW'(MAX_ENTRIES));
    assign status.blk_ok      = (32'(tix_reg) < 32'(tcnt_reg));
    assign status.sleep_ok    = (cur_reg < tcnt_reg);

    assign scan_idx = scan_reg;
    assign thr_cnt  = tcnt_reg;
    assign per_cnt  = pcnt_reg;
    assign cand_idx = cand_reg;
    assign cur_thr  = cur_reg;
    assign now      = sys_time_reg;

endmodule

@@ rtl/rts_ctrl.sv @@
module rts_ctrl
    import rts_pkg::*;
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [2:0]                        command,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic [2:0]                        kind,
    output logic [3:0]                        index,
    output logic [31:0]                       now,
    output logic                              last,
    output rts_cmd_t                          cmd,
    input  rts_status_t                       status,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  scan_idx,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  thr_cnt,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  per_cnt,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  cand_idx,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]  cur_thr,
    input  logic [31:0]                       sys_time
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_TICK, S_PRD, S_PCHK, S_TRD, S_TCHK,
        S_SCHED, S_WAIT
    } state_t;

    state_t state_reg;
    logic [2:0] op_reg;
    logic out_free;
    logic emit;

    assign out_free = !out_valid || !out_stall;
    assign in_stall = (state_reg != S_IDLE);

    always_comb
    begin
        emit = 1'b0;
        unique case (state_reg)
            S_DECODE: emit = out_free && (op_reg == CMD_ADD_THR || op_reg == CMD_ADD_PER);
            S_PCHK:   emit = out_free && status.per_hit;
            S_SCHED:  emit = out_free && status.runnable;
            S_WAIT:   emit = out_free;
            default: ;
        endcase
    end

    always_comb
    begin
        cmd = '0;
        cmd.load = (state_reg == S_IDLE) && in_valid;
        unique case (state_reg)
            S_DECODE:
            begin
                unique case (op_reg)
                    CMD_TICK:    cmd.time_inc = 1'b1;
                    CMD_SCHEDULE: cmd.scan_clr = !status.sched_empty;
                    CMD_SLEEP:   cmd.sleep_wr = status.sleep_ok;
                    CMD_ADD_THR: cmd.add_thr = !status.thr_full && out_free;
                    CMD_ADD_PER: cmd.add_per = !status.per_full && out_free;
                    CMD_SET_BLK: cmd.set_blk = status.blk_ok;
                    default: ;
                endcase
            end
            S_TICK:  cmd.scan_clr = 1'b1;
            S_PRD:   cmd.scan_clr = status.per_end;
            S_PCHK:
            begin
                if (out_free)
                begin
                    cmd.per_upd = status.per_hit;
                    cmd.scan_inc = 1'b1;
                end
            end
            S_TCHK:
            begin
                cmd.thr_wake = 1'b1;
                cmd.scan_inc = 1'b1;
            end
            S_SCHED:
            begin
                if (status.runnable)
                    cmd.sched_take = out_free;
                else if (!status.sched_end)
                    cmd.scan_inc = 1'b1;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            op_reg    <= '0;
            out_valid <= 1'b0;
            kind      <= '0;
            index     <= '0;
            now       <= '0;
            last      <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall && !emit)
                out_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        op_reg    <= command;
                        state_reg <= S_DECODE;
                    end
                end
                S_DECODE:
                begin
                    if (op_reg == CMD_TICK)
                        state_reg <= S_TICK;
                    else if (op_reg == CMD_SCHEDULE)
                    begin
                        if (status.sched_empty)
                            state_reg <= S_WAIT;
                        else
                            state_reg <= S_SCHED;
                    end
                    else if (op_reg == CMD_ADD_THR || op_reg == CMD_ADD_PER)
                    begin
                        if (out_free)
                        begin
                            out_valid <= 1'b1;
                            last      <= 1'b1;
                            now       <= sys_time;
                            state_reg <= S_IDLE;
                            if ((op_reg == CMD_ADD_THR) ? status.thr_full : status.per_full)
                            begin
                                kind  <= KIND_FULL;
                                index <= '0;
                            end
                            else
                            begin
                                kind  <= KIND_OK;
                                index <= 4'((op_reg == CMD_ADD_THR) ? thr_cnt : per_cnt);
                            end
                        end
                    end
                    else
                        state_reg <= S_IDLE;
                end
                S_TICK:  state_reg <= S_PRD;
                S_PRD:   state_reg <= status.per_end ? S_TRD : S_PCHK;
                S_PCHK:
                begin
                    if (out_free)
                    begin
                        if (status.per_hit)
                        begin
                            out_valid <= 1'b1;
                            kind      <= KIND_FIRE;
                            index     <= 4'(scan_idx);
                            last      <= 1'b0;
                            now       <= sys_time;
                        end
                        state_reg <= S_PRD;
                    end
                end
                S_TRD:   state_reg <= status.thr_end ? S_WAIT : S_TCHK;
                S_TCHK:  state_reg <= S_TRD;
                S_SCHED:
                begin
                    if (status.runnable)
                    begin
                        if (out_free)
                        begin
                            out_valid <= 1'b1;
                            kind      <= KIND_OK;
                            index     <= 4'(cand_idx);
                            last      <= 1'b1;
                            now       <= sys_time;
                            state_reg <= S_IDLE;
                        end
                    end
                    else if (status.sched_end)
                        state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    if (out_free)
                    begin
                        out_valid <= 1'b1;
                        last      <= 1'b1;
                        now       <= sys_time;
                        if (op_reg == CMD_TICK)
                        begin
                            kind  <= KIND_DONE;
                            index <= '0;
                        end
                        else
                        begin
                            kind  <= KIND_NONE;
                            index <= 4'(cur_thr);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule
